FILE: hw/rtl/gpcs_pkg.sv
// ----------------------------------------------------------------------------
// gpcs_pkg
// Shared widths, codes and control types of the gripper pair current supervisor.
// ----------------------------------------------------------------------------
`default_nettype none

package gpcs_pkg;

   localparam int CURRENT_BITS = 16;
   localparam int COUNT_BITS   = 16;

   localparam int TIME_BITS      = 32;
   localparam int CFG_BITS       = 16;
   localparam int CSR_INDEX_BITS = 3;

   // divider widths: dividend is avg*n + x, divisor is n+1
   localparam int PROD_BITS = CURRENT_BITS + COUNT_BITS;
   localparam int DVD_BITS  = PROD_BITS + 1;
   localparam int DVS_BITS  = COUNT_BITS + 1;
   localparam int STEP_BITS = $clog2(CURRENT_BITS + 1);

   typedef logic [1:0] action_type;
   localparam action_type ACT_SAMPLE  = 2'd0;
   localparam action_type ACT_EXTEND  = 2'd1;
   localparam action_type ACT_RETRACT = 2'd2;

   typedef logic [1:0] status_type;
   localparam status_type STAT_NONE    = 2'd0;
   localparam status_type STAT_DONE    = 2'd1;
   localparam status_type STAT_FAILED  = 2'd2;
   localparam status_type STAT_TIMEOUT = 2'd3;

   typedef logic [1:0] motor_type;
   localparam motor_type MOTOR_NONE    = 2'd0;
   localparam motor_type MOTOR_EXTEND  = 2'd1;
   localparam motor_type MOTOR_RETRACT = 2'd2;

   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;
   localparam csr_index_type CSR_SETTLE_DELAY = 3'd0;
   localparam csr_index_type CSR_TIMEOUT      = 3'd1;
   localparam csr_index_type CSR_IDLE_LEVEL   = 3'd2;
   localparam csr_index_type CSR_START_LEVEL  = 3'd3;
   localparam csr_index_type CSR_PAIR_SIDE    = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_MUL,
      ST_LOAD,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic capture;
      logic eval;
      logic mul;
      logic load;
      logic step;
      logic sel_rear;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic fold_front;
      logic fold_rear;
      logic fold_rear_q;
      logic div_last;
   } stat_type;

endpackage

`default_nettype wire

FILE: hw/rtl/gpcs_ctrl.sv
// ----------------------------------------------------------------------------
// gpcs_ctrl
// Sequencer: takes a word, runs evaluation and, for each folded finger, the
// multiply and divide passes, then hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module gpcs_ctrl (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  wire                 rsp_stall,
   input  gpcs_pkg::stat_type  stat,
   output gpcs_pkg::cmd_type   cmd
);

   gpcs_pkg::state_type state_ff, state_in;
   logic sel_rear_ff, sel_rear_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in    = state_ff;
      sel_rear_in = sel_rear_ff;
      unique case (state_ff)
         gpcs_pkg::ST_IDLE: begin
            if (req_valid) state_in = gpcs_pkg::ST_EVAL;
         end
         gpcs_pkg::ST_EVAL: begin
            if (stat.fold_front || stat.fold_rear) begin
               state_in    = gpcs_pkg::ST_MUL;
               sel_rear_in = !stat.fold_front;
            end else begin
               state_in = gpcs_pkg::ST_DONE;
            end
         end
         gpcs_pkg::ST_MUL:  state_in = gpcs_pkg::ST_LOAD;
         gpcs_pkg::ST_LOAD: state_in = gpcs_pkg::ST_DIV;
         gpcs_pkg::ST_DIV: begin
            if (stat.div_last) begin
               if (!sel_rear_ff && stat.fold_rear_q) begin
                  state_in    = gpcs_pkg::ST_MUL;
                  sel_rear_in = 1'b1;
               end else begin
                  state_in = gpcs_pkg::ST_DONE;
               end
            end
         end
         gpcs_pkg::ST_DONE: begin
            if (out_free) state_in = gpcs_pkg::ST_IDLE;
         end
         default: state_in = gpcs_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd          = '0;
      cmd.capture  = (state_ff == gpcs_pkg::ST_IDLE) && req_valid;
      cmd.eval     = (state_ff == gpcs_pkg::ST_EVAL);
      cmd.mul      = (state_ff == gpcs_pkg::ST_MUL);
      cmd.load     = (state_ff == gpcs_pkg::ST_LOAD);
      cmd.step     = (state_ff == gpcs_pkg::ST_DIV);
      cmd.sel_rear = sel_rear_ff;
      cmd.load_out = (state_ff == gpcs_pkg::ST_DONE) && out_free;
      req_stall    = (state_ff != gpcs_pkg::ST_IDLE);
      rsp_valid    = rsp_valid_ff;
   end

   // result word stays until taken, a new one may replace it in the same cycle
   assign rsp_valid_in = cmd.load_out ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gpcs_pkg::ST_IDLE;
         sel_rear_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sel_rear_ff  <= sel_rear_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/gpcs_datapath.sv
// ----------------------------------------------------------------------------
// gpcs_datapath
// Configuration registers, move state, window checks, shared multiplier and
// serial divider for the running averages, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module gpcs_datapath (
   input  wire                                    clock,
   input  wire                                    reset,
   input  gpcs_pkg::cmd_type                      cmd,
   output gpcs_pkg::stat_type                     stat,
   input  wire                                    csr_write,
   input  wire  [gpcs_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  wire  [gpcs_pkg::CFG_BITS-1:0]          csr_data,
   input  wire  [1:0]                             req_action,
   input  wire  [gpcs_pkg::TIME_BITS-1:0]         req_now_ms,
   input  wire  [gpcs_pkg::CURRENT_BITS-1:0]      req_front_current,
   input  wire  [gpcs_pkg::CURRENT_BITS-1:0]      req_rear_current,
   output logic [1:0]                             rsp_status,
   output logic [1:0]                             rsp_motor_command,
   output logic [gpcs_pkg::CURRENT_BITS-1:0]      rsp_front_average,
   output logic [gpcs_pkg::CURRENT_BITS-1:0]      rsp_rear_average,
   output logic                                   rsp_front_started,
   output logic                                   rsp_rear_started
);

   localparam int CB = gpcs_pkg::CURRENT_BITS;
   localparam int NB = gpcs_pkg::COUNT_BITS;
   localparam int TB = gpcs_pkg::TIME_BITS;
   localparam int FB = gpcs_pkg::CFG_BITS;

   // configuration
   logic [FB-1:0] settle_ff, timeout_ff, idle_lvl_ff, start_lvl_ff;

   // captured word
   gpcs_pkg::action_type action_ff;
   logic [TB-1:0] now_ff;
   logic [CB-1:0] fc_ff, rc_ff;

   // move state
   logic [TB-1:0] start_time_ff;
   gpcs_pkg::motor_type last_move_ff;
   logic front_flag_ff, rear_flag_ff;
   logic [CB-1:0] front_avg_ff, rear_avg_ff;
   logic [NB-1:0] front_cnt_ff, rear_cnt_ff;

   // evaluation result
   gpcs_pkg::status_type stat_ff;
   gpcs_pkg::motor_type motor_ff;
   logic fold_rear_q_ff;

   // multiplier and divider
   logic [gpcs_pkg::PROD_BITS-1:0] prod_ff;
   logic [gpcs_pkg::DVS_BITS-1:0]  divisor_ff, rem_ff;
   logic [CB-1:0]                  quo_ff;
   logic [gpcs_pkg::STEP_BITS-1:0] step_ff;

   logic [TB-1:0] elapsed;
   logic in_window, late;
   logic front_above, rear_above, front_reach, rear_reach;
   logic front_flag_new, rear_flag_new;
   logic [CB-1:0] sel_avg, sel_x;
   logic [NB-1:0] sel_cnt, cnt_next;
   logic [gpcs_pkg::DVD_BITS-1:0] dividend;
   logic [gpcs_pkg::DVS_BITS:0] trial, diff;
   logic trial_ge;
   logic [CB-1:0] quo_next;

   assign elapsed   = now_ff - start_time_ff;
   assign in_window = (elapsed >= TB'(settle_ff)) && (elapsed <= TB'(timeout_ff));
   assign late      = (elapsed > TB'(timeout_ff));

   assign front_above = (CB'(fc_ff) > CB'(idle_lvl_ff));
   assign rear_above  = (CB'(rc_ff) > CB'(idle_lvl_ff));
   assign front_reach = (CB'(fc_ff) >= CB'(start_lvl_ff));
   assign rear_reach  = (CB'(rc_ff) >= CB'(start_lvl_ff));
   assign front_flag_new = front_flag_ff || front_reach;
   assign rear_flag_new  = rear_flag_ff || rear_reach;

   always_comb begin
      stat             = '0;
      stat.fold_front  = (action_ff == gpcs_pkg::ACT_SAMPLE) && in_window && front_above;
      stat.fold_rear   = (action_ff == gpcs_pkg::ACT_SAMPLE) && in_window && rear_above;
      stat.fold_rear_q = fold_rear_q_ff;
      stat.div_last    = (step_ff == gpcs_pkg::STEP_BITS'(1));
   end

   assign sel_avg = cmd.sel_rear ? rear_avg_ff : front_avg_ff;
   assign sel_cnt = cmd.sel_rear ? rear_cnt_ff : front_cnt_ff;
   assign sel_x   = cmd.sel_rear ? rc_ff : fc_ff;
   assign cnt_next = (sel_cnt == {NB{1'b1}}) ? sel_cnt : sel_cnt + NB'(1);

   assign dividend = {1'b0, prod_ff} + gpcs_pkg::DVD_BITS'(sel_x);

   // restoring divide, one quotient bit per cycle
   assign trial    = {rem_ff, quo_ff[CB-1]};
   assign diff     = trial - {1'b0, divisor_ff};
   assign trial_ge = (trial >= {1'b0, divisor_ff});
   assign quo_next = {quo_ff[CB-2:0], trial_ge};

   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ff    <= FB'(100);
         timeout_ff   <= FB'(5000);
         idle_lvl_ff  <= FB'(64);
         start_lvl_ff <= FB'(128);
      end else if (csr_write) begin
         unique case (csr_index)
            gpcs_pkg::CSR_SETTLE_DELAY: settle_ff    <= csr_data;
            gpcs_pkg::CSR_TIMEOUT:      timeout_ff   <= csr_data;
            gpcs_pkg::CSR_IDLE_LEVEL:   idle_lvl_ff  <= csr_data;
            gpcs_pkg::CSR_START_LEVEL:  start_lvl_ff <= csr_data;
            // side tag only names the pair, it changes no result
            gpcs_pkg::CSR_PAIR_SIDE:    ;
            default:                    ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         action_ff <= req_action;
         now_ff    <= req_now_ms;
         fc_ff     <= req_front_current;
         rc_ff     <= req_rear_current;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_time_ff <= '0;
         last_move_ff  <= gpcs_pkg::MOTOR_NONE;
         front_flag_ff <= 1'b0;
         rear_flag_ff  <= 1'b0;
         front_avg_ff  <= '0;
         rear_avg_ff   <= '0;
         front_cnt_ff  <= '0;
         rear_cnt_ff   <= '0;
      end else if (cmd.eval) begin
         priority if (action_ff == gpcs_pkg::ACT_EXTEND ||
                      action_ff == gpcs_pkg::ACT_RETRACT) begin
            start_time_ff <= now_ff;
            last_move_ff  <= action_ff;
            front_flag_ff <= 1'b0;
            rear_flag_ff  <= 1'b0;
            front_avg_ff  <= '0;
            rear_avg_ff   <= '0;
            front_cnt_ff  <= '0;
            rear_cnt_ff   <= '0;
         end else if (action_ff == gpcs_pkg::ACT_SAMPLE && in_window) begin
            front_flag_ff <= front_flag_new;
            rear_flag_ff  <= rear_flag_new;
         end else if (action_ff == gpcs_pkg::ACT_SAMPLE && late &&
                      (last_move_ff == gpcs_pkg::MOTOR_EXTEND ||
                       last_move_ff == gpcs_pkg::MOTOR_RETRACT)) begin
            // timeout reverses the move and restarts the window
            start_time_ff <= now_ff;
            last_move_ff  <= (last_move_ff == gpcs_pkg::MOTOR_EXTEND) ?
                             gpcs_pkg::MOTOR_RETRACT : gpcs_pkg::MOTOR_EXTEND;
            front_flag_ff <= 1'b0;
            rear_flag_ff  <= 1'b0;
            front_avg_ff  <= '0;
            rear_avg_ff   <= '0;
            front_cnt_ff  <= '0;
            rear_cnt_ff   <= '0;
         end else begin
            start_time_ff <= start_time_ff;
         end
      end else if (cmd.step && stat.div_last) begin
         if (cmd.sel_rear) begin
            rear_avg_ff <= quo_next;
            rear_cnt_ff <= cnt_next;
         end else begin
            front_avg_ff <= quo_next;
            front_cnt_ff <= cnt_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.eval) begin
         fold_rear_q_ff <= stat.fold_rear;
         stat_ff        <= gpcs_pkg::STAT_NONE;
         motor_ff       <= gpcs_pkg::MOTOR_NONE;
         priority if (action_ff == gpcs_pkg::ACT_EXTEND ||
                      action_ff == gpcs_pkg::ACT_RETRACT) begin
            motor_ff <= action_ff;
         end else if (action_ff == gpcs_pkg::ACT_SAMPLE && in_window) begin
            if (!front_above && !rear_above) begin
               stat_ff <= (front_flag_new && rear_flag_new) ?
                          gpcs_pkg::STAT_DONE : gpcs_pkg::STAT_FAILED;
            end
         end else if (action_ff == gpcs_pkg::ACT_SAMPLE && late) begin
            stat_ff <= gpcs_pkg::STAT_TIMEOUT;
            if (last_move_ff == gpcs_pkg::MOTOR_EXTEND) begin
               motor_ff <= gpcs_pkg::MOTOR_RETRACT;
            end else if (last_move_ff == gpcs_pkg::MOTOR_RETRACT) begin
               motor_ff <= gpcs_pkg::MOTOR_EXTEND;
            end
         end else begin
            stat_ff <= gpcs_pkg::STAT_NONE;
         end
      end
   end

   // quotient is known to fit the average width, so the top of the dividend
   // preloads the remainder and only the low bits are stepped
   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         prod_ff <= {{NB{1'b0}}, sel_avg} * {{CB{1'b0}}, sel_cnt};
      end
      if (cmd.load) begin
         divisor_ff <= {1'b0, sel_cnt} + gpcs_pkg::DVS_BITS'(1);
         rem_ff     <= dividend[gpcs_pkg::DVD_BITS-1:CB];
         quo_ff     <= dividend[CB-1:0];
         step_ff    <= gpcs_pkg::STEP_BITS'(CB);
      end else if (cmd.step) begin
         rem_ff  <= trial_ge ? diff[gpcs_pkg::DVS_BITS-1:0] : trial[gpcs_pkg::DVS_BITS-1:0];
         quo_ff  <= quo_next;
         step_ff <= step_ff - gpcs_pkg::STEP_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_status        <= stat_ff;
         rsp_motor_command <= motor_ff;
         rsp_front_average <= front_avg_ff;
         rsp_rear_average  <= rear_avg_ff;
         rsp_front_started <= front_flag_ff;
         rsp_rear_started  <= rear_flag_ff;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/gripper_pair_current_supervisor.sv
// ----------------------------------------------------------------------------
// gripper_pair_current_supervisor
// Current-draw supervisor for the two fingers of one gripper pair.
// ----------------------------------------------------------------------------
// Each request word is either an extend or retract command, which starts a
// new move, or a pair of finger current samples (unsigned Q8.8 amps) with a
// millisecond timestamp; every word gives exactly one response word carrying
// status, motor command, both running averages and both started flags. Items
// are handled one at a time: a word is captured and evaluated, then for each
// finger whose average is folded the shared multiplier forms avg*n, and the
// divider is loaded and steps out one quotient bit per cycle; multiplier and
// divider serve both fingers in turn before the result is loaded for output.
// A finished response sits in an output register, so the next request is
// taken while it waits. Configuration writes are taken at any time but
// should only be issued while the block is idle.
`default_nettype none

module gripper_pair_current_supervisor (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   output logic                                req_stall,
   input  wire  [1:0]                          req_action,
   input  wire  [gpcs_pkg::TIME_BITS-1:0]      req_now_ms,
   input  wire  [gpcs_pkg::CURRENT_BITS-1:0]   req_front_current,
   input  wire  [gpcs_pkg::CURRENT_BITS-1:0]   req_rear_current,
   output logic                                rsp_valid,
   input  wire                                 rsp_stall,
   output logic [1:0]                          rsp_status,
   output logic [1:0]                          rsp_motor_command,
   output logic [gpcs_pkg::CURRENT_BITS-1:0]   rsp_front_average,
   output logic [gpcs_pkg::CURRENT_BITS-1:0]   rsp_rear_average,
   output logic                                rsp_front_started,
   output logic                                rsp_rear_started,
   input  wire                                 csr_write,
   input  wire  [gpcs_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire  [gpcs_pkg::CFG_BITS-1:0]       csr_data
);

   gpcs_pkg::cmd_type  cmd;
   gpcs_pkg::stat_type stat;

   gpcs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   gpcs_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_action        (req_action),
      .req_now_ms        (req_now_ms),
      .req_front_current (req_front_current),
      .req_rear_current  (req_rear_current),
      .rsp_status        (rsp_status),
      .rsp_motor_command (rsp_motor_command),
      .rsp_front_average (rsp_front_average),
      .rsp_rear_average  (rsp_rear_average),
      .rsp_front_started (rsp_front_started),
      .rsp_rear_started  (rsp_rear_started)
   );

endmodule

`default_nettype wire

FILE: hw/rtl/gpcs_checker.sv
// ----------------------------------------------------------------------------
// gpcs_checker
// Port-level checks on response words of the current supervisor.
// ----------------------------------------------------------------------------
`default_nettype none

module gpcs_checker (
   input wire                               clock,
   input wire                               reset,
   input wire                               rsp_valid,
   input wire                               rsp_stall,
   input wire [1:0]                         rsp_status,
   input wire [1:0]                         rsp_motor_command,
   input wire [gpcs_pkg::CURRENT_BITS-1:0]  rsp_front_average,
   input wire [gpcs_pkg::CURRENT_BITS-1:0]  rsp_rear_average,
   input wire                               rsp_front_started,
   input wire                               rsp_rear_started
);

   // a held word's status, motor command and averages must not change under stall
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_motor_command) && $stable(rsp_front_average) &&
      $stable(rsp_rear_average))
      else $error("response word changed while stalled");

   // a word that starts a move shows cleared averages and flags
   a_move_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_motor_command != gpcs_pkg::MOTOR_NONE |->
      rsp_front_average == '0 && rsp_rear_average == '0 &&
      !rsp_front_started && !rsp_rear_started)
      else $error("new move without cleared state");

   // motor drive only comes with a command echo or a timeout
   a_motor_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_motor_command != gpcs_pkg::MOTOR_NONE |->
      rsp_status == gpcs_pkg::STAT_NONE || rsp_status == gpcs_pkg::STAT_TIMEOUT)
      else $error("motor drive with wrong status");

   a_done_started: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == gpcs_pkg::STAT_DONE |->
      rsp_front_started && rsp_rear_started)
      else $error("done without both fingers started");

   a_failed_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == gpcs_pkg::STAT_FAILED |->
      !(rsp_front_started && rsp_rear_started))
      else $error("failed although both fingers started");

endmodule

bind gripper_pair_current_supervisor gpcs_checker u_gpcs_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_status        (rsp_status),
   .rsp_motor_command (rsp_motor_command),
   .rsp_front_average (rsp_front_average),
   .rsp_rear_average  (rsp_rear_average),
   .rsp_front_started (rsp_front_started),
   .rsp_rear_started  (rsp_rear_started)
);

`default_nettype wire
